### sv/ssrch_pkg.sv
// ssrch_pkg: shared types, constants and helpers for the stream substring search
// used by the interfaces, the word queue, the match back end and the top level
// no dependencies
`default_nettype none

package ssrch_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 32;
  localparam int OUT_BITS    = 32;
  localparam int CFG_BITS    = 64;
  localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
  localparam int IDX_BITS    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2*CFG_BITS-1:0] pattern;
    logic [4:0]            length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic pop;
    logic pop_last;
    logic matched;
  } back_status_t;

  // length as used: zero reads as one, anything above the maximum as the maximum
  function automatic logic [LEN_BITS-1:0] used_len(input logic [4:0] raw);
    logic [LEN_BITS-1:0] len;
    if (raw == 5'd0) begin
      len = LEN_BITS'(1);
    end else if (32'(raw) > PATTERN_MAX) begin
      len = LEN_BITS'(PATTERN_MAX);
    end else begin
      len = LEN_BITS'(raw);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/ssrch_if.sv
// ssrch_in_if / ssrch_out_if: valid-ready channels for region bytes and results
// payload types come from ssrch_pkg
`default_nettype none

interface ssrch_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ssrch_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [ssrch_pkg::OUT_BITS-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

`default_nettype wire

### sv/ssrch_queue.sv
// ssrch_queue: front end, accepts region bytes into a two-entry queue
// depends on ssrch_pkg and ssrch_in_if
`default_nettype none

module ssrch_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  ssrch_in_if.sink                      bytes,
  output ssrch_pkg::item_t              head,
  output logic                          head_valid,
  input  wire logic                     pop,
  output ssrch_pkg::queue_status_t      status
);

  ssrch_pkg::item_t                entries [ssrch_pkg::QUEUE_DEPTH];
  logic                            wr_ptr;
  logic                            rd_ptr;
  logic [ssrch_pkg::QCNT_BITS-1:0] count;
  logic                            push;

  assign bytes.ready  = (count != ssrch_pkg::QCNT_BITS'(ssrch_pkg::QUEUE_DEPTH));
  assign push         = bytes.valid && bytes.ready;
  assign head_valid   = (count != '0);
  assign head         = entries[rd_ptr];
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{data_byte: bytes.data_byte, last_byte: bytes.last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/ssrch_back.sv
// ssrch_back: byte window, saturating counter, parallel pattern compare, result register
// depends on ssrch_pkg and ssrch_out_if
`default_nettype none

module ssrch_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  ssrch_pkg::cfg_t          cfg,
  input  ssrch_pkg::item_t         head,
  input  wire logic                head_valid,
  output logic                     pop,
  ssrch_out_if.source              results,
  output ssrch_pkg::back_status_t  status
);

  localparam int PM = ssrch_pkg::PATTERN_MAX;
  localparam int OB = ssrch_pkg::OFFSET_BITS;
  localparam int LB = ssrch_pkg::LEN_BITS;

  logic [7:0]                    window [PM];
  logic [7:0]                    win_next [PM];
  logic [OB-1:0]                 bytes_seen;
  logic [OB-1:0]                 seen_next;
  logic                          matched;
  logic [LB-1:0]                 len;
  logic [PM-1:0]                 eq;
  logic                          hit;
  logic                          res_valid;
  logic                          res_found;
  logic [ssrch_pkg::OUT_BITS-1:0] res_offset;
  logic                          emit;
  logic [OB-1:0]                 offset;

  assign len = ssrch_pkg::used_len(cfg.length);
  assign pop = head_valid && (!res_valid || results.ready);

  always_comb begin
    win_next[0] = head.data_byte;
    for (int j = 1; j < PM; j++) begin
      win_next[j] = window[j-1];
    end
  end

  // window entry j lines up with pattern byte len-1-j
  always_comb begin
    logic [LB-1:0] pidx;
    for (int j = 0; j < PM; j++) begin
      pidx = len - LB'(1) - LB'(j);
      if (LB'(j) < len) begin
        eq[j] = (win_next[j] ==
                 cfg.pattern[8*pidx[ssrch_pkg::IDX_BITS-1:0] +: 8]);
      end else begin
        eq[j] = 1'b1;
      end
    end
  end

  assign seen_next = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;
  assign hit       = (&eq) && (seen_next >= OB'(len));
  assign offset    = seen_next - OB'(len);
  assign emit      = !matched && (hit || head.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      matched    <= 1'b0;
      bytes_seen <= '0;
      for (int j = 0; j < PM; j++) begin
        window[j] <= 8'd0;
      end
    end else if (pop) begin
      if (head.last_byte) begin
        matched    <= 1'b0;
        bytes_seen <= '0;
        for (int j = 0; j < PM; j++) begin
          window[j] <= 8'd0;
        end
      end else if (!matched) begin
        matched    <= hit;
        bytes_seen <= seen_next;
        for (int j = 0; j < PM; j++) begin
          window[j] <= win_next[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= emit;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_found  <= hit;
      res_offset <= hit ? ssrch_pkg::OUT_BITS'(offset) : '0;
    end
  end

  assign results.valid        = res_valid;
  assign results.found        = res_found;
  assign results.match_offset = res_offset;

  assign status.pop      = pop;
  assign status.pop_last = pop && head.last_byte;
  assign status.matched  = matched;

endmodule

`default_nettype wire

### sv/stream_substring_search_core.sv
// channel   dir  payload                      word moved
// bytes     in   data_byte[7:0], last_byte    one region byte
// results   out  found, match_offset[31:0]    one search result
//
// one byte per cycle sustained while results is not stalled; a byte is written into the queue when
// it is accepted and, once popped, reaches the result register (window compare)
// the parallel compare covers the whole 16-byte window at once
// rst is synchronous and clears queue, window, counter and result valid
// a stalled results channel fills the two-entry queue, then bytes.ready drops
// stream_substring_search_core: top level, config registers, queue and back end
// depends on ssrch_pkg, ssrch_if, ssrch_queue, ssrch_back
`default_nettype none

module stream_substring_search_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  ssrch_in_if.sink                          bytes,
  ssrch_out_if.source                       results,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [ssrch_pkg::CFG_BITS-1:0] cfg_data
);

  ssrch_pkg::cfg_t          cfg;
  ssrch_pkg::item_t         head;
  logic                     head_valid;
  logic                     pop;
  ssrch_pkg::queue_status_t q_status;
  ssrch_pkg::back_status_t  b_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern <= '0;
      cfg.length  <= 5'd1;
    end else if (cfg_we) begin
      unique case (ssrch_pkg::reg_index_t'(cfg_index))
        ssrch_pkg::REG_PATTERN_LOW:
          cfg.pattern[ssrch_pkg::CFG_BITS-1:0] <= cfg_data;
        ssrch_pkg::REG_PATTERN_HIGH:
          cfg.pattern[2*ssrch_pkg::CFG_BITS-1:ssrch_pkg::CFG_BITS] <= cfg_data;
        ssrch_pkg::REG_PATTERN_LEN:
          cfg.length <= cfg_data[4:0];
        default: cfg <= cfg;
      endcase
    end
  end

  ssrch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .status     (q_status)
  );

  ssrch_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .results    (results),
    .status     (b_status)
  );

`ifndef SYNTHESIS
  a_region_clears: assert property (@(posedge clk) disable iff (rst)
    b_status.pop_last |=> !b_status.matched)
    else $error("match flag survived end of region");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready && !pop) |=>
      (q_status.count == $past(q_status.count) + 1'b1))
    else $error("queue count did not follow a push");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.found) |-> (results.match_offset == '0))
    else $error("not-found result carries an offset");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_status.count != '0))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
